>>> sv/mvcc_version_ring_defines.svh
// Assertion macros used by the ring controller
`ifndef MVCC_VERSION_RING_DEFINES_SVH
`define MVCC_VERSION_RING_DEFINES_SVH

// implication checked every cycle outside reset
`define MVR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvr check failed");

// implication checked in the cycle after the antecedent
`define MVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvr check failed");

`endif

>>> sv/mvr_pkg.sv
`timescale 1ns / 1ps
package mvr_pkg;
  localparam int RingSlotsDef = 16;
  localparam int StampBitsDef = 48;

  typedef enum logic [2:0] {
    ACT_READ     = 3'd0,
    ACT_PREWRITE = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_FIN_WR   = 3'd3,
    ACT_FIN_DEL  = 3'd4
  } action_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request, read newest/oldest/next slot entries
    logic decide;    // evaluate request from fetched entries
    logic walk;      // one backward read-walk step
    logic gc;        // one reclaim step
    logic commit;    // apply prewrite / delete / finish updates and emit
  } dp_cmd_t;

  // status back to controller
  typedef struct packed {
    logic done;      // result decided without more stepping
    logic need_walk;
    logic need_gc;
    logic walk_done;
    logic gc_done;
  } dp_stat_t;
endpackage

>>> sv/mvcc_version_ring.sv
`timescale 1ns / 1ps
// Version ring for one row: serves read, prewrite, delete and finish requests.
// Raise start while busy is low; busy stays high until the result, which sits
// on the result ports for one cycle under done and cannot be held off.
// A request decided at once passes the decide state and then shows done in the
// output state; one that updates the ring passes the apply state on the way.
// A backward read walk adds a walk step per slot it examines and a reclaim
// sweep one step per slot reclaimed plus a final check, both of which go
// through the slot memories one entry a cycle.
module mvcc_version_ring #(
  parameter int RING_SLOTS = mvr_pkg::RingSlotsDef,
  parameter int STAMP_BITS = mvr_pkg::StampBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic [2:0]            action,
  input  logic [STAMP_BITS-1:0] txn_ts,
  input  logic [STAMP_BITS-1:0] txn_id,
  input  logic [STAMP_BITS-1:0] commit_stamp,
  input  logic                  committed,
  input  logic [STAMP_BITS-1:0] oldest_active_ts,
  input  logic                  writer_found,
  input  logic [STAMP_BITS-1:0] writer_commit_ts,
  output logic                  status,
  output logic [3:0]            version_slot,
  output logic [3:0]            source_slot,
  output logic                  fresh_version
);
  import mvr_pkg::*;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mvr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cmd(cmd), .stat(stat)
  );

  mvr_datapath #(.RING_SLOTS(RING_SLOTS), .STAMP_BITS(STAMP_BITS)) u_dp (
    .clk(clk), .rst(rst), .action(action), .txn_ts(txn_ts), .txn_id(txn_id),
    .commit_stamp(commit_stamp), .committed(committed),
    .oldest_active_ts(oldest_active_ts), .writer_found(writer_found),
    .writer_commit_ts(writer_commit_ts), .cmd(cmd), .stat(stat),
    .res_status(status), .res_version(version_slot), .res_source(source_slot),
    .res_fresh(fresh_version)
  );
endmodule

>>> sv/mvr_datapath.sv
`timescale 1ns / 1ps
module mvr_datapath #(
  parameter int RING_SLOTS = mvr_pkg::RingSlotsDef,
  parameter int STAMP_BITS = mvr_pkg::StampBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            action,
  input  logic [STAMP_BITS-1:0] txn_ts,
  input  logic [STAMP_BITS-1:0] txn_id,
  input  logic [STAMP_BITS-1:0] commit_stamp,
  input  logic                  committed,
  input  logic [STAMP_BITS-1:0] oldest_active_ts,
  input  logic                  writer_found,
  input  logic [STAMP_BITS-1:0] writer_commit_ts,
  input  mvr_pkg::dp_cmd_t      cmd,
  output mvr_pkg::dp_stat_t     stat,
  output logic                  res_status,
  output logic [3:0]            res_version,
  output logic [3:0]            res_source,
  output logic                  res_fresh
);
  import mvr_pkg::*;
  localparam int SW = $clog2(RING_SLOTS);
  localparam logic [STAMP_BITS-1:0] INF = '1;
  localparam logic [SW-1:0] LAST = SW'(RING_SLOTS - 1);

  logic [STAMP_BITS-1:0] mem_begin [RING_SLOTS];
  logic [STAMP_BITS-1:0] mem_end   [RING_SLOTS];
  logic [RING_SLOTS-1:0] begin_pend, end_txn;
  logic [RING_SLOTS-1:0] written;
  logic [SW-1:0] newest, oldest;
  logic pending;

  logic [2:0] act;
  logic [STAMP_BITS-1:0] ts, id, cts, mts, wcts;
  logic cmt, fnd;
  logic [SW-1:0] walk_i;
  logic [SW-1:0] gc_i;

  // registered read ports
  logic [STAMP_BITS-1:0] b_nw, e_nw, b_old, b_nx, e_old, rd_b, rd_e;

  function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i);
    return (i == LAST) ? '0 : SW'(i + 1'b1);
  endfunction
  function automatic logic [SW-1:0] prv(input logic [SW-1:0] i);
    return (i == '0) ? LAST : SW'(i - 1'b1);
  endfunction

  // unwritten slots read as zero (slot 0 has explicit reset values)
  function automatic logic [STAMP_BITS-1:0] rb(input logic [SW-1:0] i,
      input logic [RING_SLOTS-1:0] w, input logic [STAMP_BITS-1:0] d);
    return w[i] ? d : '0;
  endfunction

  logic [SW-1:0] nx;
  assign nx = nxt(newest);

  logic deleted, decided, dec_status;
  logic [SW-1:0] dec_ver;
  logic dec_walk, dec_gc;

  always_comb begin
    deleted    = !end_txn[newest] && (e_nw != INF);
    decided    = 1'b1;
    dec_status = 1'b1;
    dec_ver    = '0;
    dec_walk   = 1'b0;
    dec_gc     = 1'b0;
    if (act <= ACT_DELETE && deleted) begin
      dec_status = 1'b1;
    end else begin
      unique case (act)
        ACT_READ: begin
          if (ts < b_old) begin
            dec_status = 1'b1;
          end else if (ts > b_nw) begin
            dec_status = 1'b0;
            dec_ver = (end_txn[newest] && fnd && wcts <= ts) ? nx : newest;
          end else if (newest != oldest) begin
            decided  = 1'b0;
            dec_walk = 1'b1;
          end else begin
            dec_status = 1'b0;
            dec_ver = newest;
          end
        end
        ACT_PREWRITE, ACT_DELETE: begin
          if (pending || ts < b_nw) begin
            dec_status = 1'b1;
          end else if (act == ACT_PREWRITE && nx == oldest && mts > e_old) begin
            decided = 1'b0;
            dec_gc  = 1'b1;
          end else begin
            decided = 1'b0;
          end
        end
        ACT_FIN_WR: begin
          if (!pending || !begin_pend[nx] || b_nx != id) dec_status = 1'b1;
          else decided = 1'b0;
        end
        ACT_FIN_DEL: begin
          if (!pending || begin_pend[nx] || !end_txn[newest] || e_nw != id)
            dec_status = 1'b1;
          else decided = 1'b0;
        end
        default: dec_status = 1'b1;
      endcase
    end
  end

  logic [SW-1:0] walk_prev;
  assign walk_prev = prv(walk_i);

  always_comb begin
    stat.done      = decided;
    stat.need_walk = dec_walk;
    stat.need_gc   = dec_gc;
    stat.walk_done = (rd_b < ts) || (walk_i == oldest);
    stat.gc_done   = (gc_i == newest) || !(rd_e < mts);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action; ts <= txn_ts; id <= txn_id; cts <= commit_stamp;
      cmt <= committed; mts <= oldest_active_ts; fnd <= writer_found;
      wcts <= writer_commit_ts;
      b_nw  <= rb(newest, written, mem_begin[newest]);
      e_nw  <= rb(newest, written, mem_end[newest]);
      b_old <= rb(oldest, written, mem_begin[oldest]);
      e_old <= rb(oldest, written, mem_end[oldest]);
      b_nx  <= rb(nx, written, mem_begin[nx]);
      walk_i <= prv(newest);
      gc_i   <= oldest;
    end
    if (cmd.decide) begin
      rd_b <= rb(prv(newest), written, mem_begin[prv(newest)]);
      rd_e <= e_old;
    end
    if (cmd.walk) begin
      walk_i <= walk_prev;
      rd_b <= rb(walk_prev, written, mem_begin[walk_prev]);
    end
    if (cmd.gc) begin
      gc_i <= nxt(gc_i);
      rd_e <= rb(nxt(gc_i), written, mem_end[nxt(gc_i)]);
    end
    if (rst) begin
      mem_begin[0] <= '0;
      mem_end[0] <= INF;
    end else if (cmd.commit && act == ACT_PREWRITE) begin
      mem_begin[nx] <= id;
      mem_end[newest] <= id;
    end else if (cmd.commit && act == ACT_DELETE) begin
      mem_end[newest] <= id;
    end else if (cmd.commit && act == ACT_FIN_WR) begin
      if (cmt) begin
        mem_end[newest] <= cts;
        mem_begin[nx] <= cts;
        mem_end[nx] <= INF;
      end else begin
        mem_end[newest] <= INF;
      end
    end else if (cmd.commit && act == ACT_FIN_DEL) begin
      mem_end[newest] <= cmt ? cts : INF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_pend <= '0; end_txn <= '0; written <= RING_SLOTS'(1);
      newest <= '0; oldest <= '0; pending <= 1'b0;
      res_status <= 1'b0; res_version <= '0; res_source <= '0; res_fresh <= 1'b0;
    end else begin
      if (cmd.gc && !stat.gc_done) oldest <= nxt(oldest);
      if (cmd.decide && decided) begin
        res_status <= dec_status;
        res_version <= dec_status ? 4'd0 : 4'(dec_ver);
        res_source <= '0; res_fresh <= 1'b0;
      end
      if (cmd.walk) begin
        res_status <= 1'b0; res_source <= '0; res_fresh <= 1'b0;
        res_version <= (rd_b < ts) ? 4'(walk_i) : 4'(newest);
      end
      if (cmd.commit) begin
        res_status <= 1'b0;
        unique case (act)
          ACT_PREWRITE: begin
            pending <= 1'b1;
            if (nx == oldest) oldest <= nxt(oldest);
            begin_pend[nx] <= 1'b1; end_txn[newest] <= 1'b1;
            written[nx] <= 1'b1;
            res_version <= 4'(nx); res_source <= 4'(newest); res_fresh <= 1'b1;
          end
          ACT_DELETE: begin
            pending <= 1'b1; end_txn[newest] <= 1'b1;
            res_version <= 4'(newest); res_source <= '0; res_fresh <= 1'b0;
          end
          ACT_FIN_WR: begin
            pending <= 1'b0; end_txn[newest] <= 1'b0; begin_pend[nx] <= 1'b0;
            res_source <= '0; res_fresh <= 1'b0;
            if (cmt) begin
              newest <= nx; res_version <= 4'(nx);
            end else begin
              res_version <= 4'(newest);
            end
          end
          default: begin
            pending <= 1'b0; end_txn[newest] <= 1'b0;
            res_version <= 4'(newest); res_source <= '0; res_fresh <= 1'b0;
          end
        endcase
      end
    end
  end
endmodule

>>> sv/mvr_ctrl.sv
`timescale 1ns / 1ps
`include "mvcc_version_ring_defines.svh"
module mvr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output mvr_pkg::dp_cmd_t  cmd,
  input  mvr_pkg::dp_stat_t stat
);
  import mvr_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DEC = 6'b000010, S_WALK = 6'b000100,
    S_GC = 6'b001000, S_APPLY = 6'b010000, S_OUT = 6'b100000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.load = 1'b1; state_next = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (stat.done) state_next = S_OUT;
        else if (stat.need_walk) state_next = S_WALK;
        else if (stat.need_gc) state_next = S_GC;
        else state_next = S_APPLY;
      end
      S_WALK: begin
        // every step records its answer; the last one stands
        cmd.walk = 1'b1;
        if (stat.walk_done) state_next = S_OUT;
      end
      S_GC: begin
        if (stat.gc_done) state_next = S_APPLY;
        else cmd.gc = 1'b1;
      end
      S_APPLY: begin
        cmd.commit = 1'b1; state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  `MVR_ASSERT_NEXT(a_start_leaves_idle, clk, rst, state == S_IDLE && start, state == S_DEC)
  `MVR_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
  `MVR_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
endmodule
